/* hdl/sfr_pkg.sv */
// shared types and constants for the serial frame receiver
package sfr_pkg;

  localparam int unsigned MaxFrameSize  = 2048;
  localparam int unsigned FrameOverhead = 7;
  localparam int unsigned CheckOffset   = 5;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned SizeW   = 16;
  localparam int unsigned IndexW  = 11;
  localparam int unsigned StatusW = 4;
  localparam int unsigned CfgIdxW = 2;

  localparam logic [ByteW-1:0] StartByteRst = 8'd2;
  localparam logic [ByteW-1:0] EndByteRst   = 8'd3;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_START_BYTE = 2'd0,
    CFG_END_BYTE   = 2'd1
  } cfg_idx_e;

  typedef enum logic [StatusW-1:0] {
    ST_SKIP        = 4'd0,
    ST_HEADER      = 4'd1,
    ST_PAYLOAD     = 4'd2,
    ST_DONE        = 4'd3,
    ST_BAD_SIZE    = 4'd4,
    ST_BAD_TYPE    = 4'd5,
    ST_BAD_CHECK   = 4'd6,
    ST_BAD_VERSION = 4'd7,
    ST_BAD_END     = 4'd8
  } status_e;

  typedef enum logic [7:0] {
    PH_HUNT    = 8'b0000_0001,
    PH_SIZE_HI = 8'b0000_0010,
    PH_SIZE_LO = 8'b0000_0100,
    PH_TYPE    = 8'b0000_1000,
    PH_CHECK   = 8'b0001_0000,
    PH_VERSION = 8'b0010_0000,
    PH_PAYLOAD = 8'b0100_0000,
    PH_END     = 8'b1000_0000
  } phase_e;

  typedef struct packed {
    status_e            status;
    logic [ByteW-1:0]   payload_byte;
    logic [IndexW-1:0]  payload_index;
    logic [ByteW-1:0]   frame_type;
    logic [ByteW-1:0]   frame_version;
  } result_t;

endpackage

/* hdl/sfr_if.sv */
// channel interfaces: received bytes, parse results and register writes
interface sfr_byte_if;
  import sfr_pkg::*;
  logic             valid;
  logic             ready;
  logic [ByteW-1:0] rx_byte;
  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface sfr_result_if;
  import sfr_pkg::*;
  logic               valid;
  logic               ready;
  logic [StatusW-1:0] status;
  logic [ByteW-1:0]   payload_byte;
  logic [IndexW-1:0]  payload_index;
  logic [ByteW-1:0]   frame_type;
  logic [ByteW-1:0]   frame_version;
  modport source (output valid, output status, output payload_byte, output payload_index,
                  output frame_type, output frame_version, input ready);
  modport sink   (input valid, input status, input payload_byte, input payload_index,
                  input frame_type, input frame_version, output ready);
endinterface

interface sfr_cfg_if;
  import sfr_pkg::*;
  logic               valid;
  logic               ready;
  logic [CfgIdxW-1:0] index;
  logic [ByteW-1:0]   data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

/* hdl/sfr_cfg_regs.sv */
// start and end byte configuration registers
module sfr_cfg_regs import sfr_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               wr_valid_i,
  input  logic [CfgIdxW-1:0] wr_index_i,
  input  logic [ByteW-1:0]   wr_data_i,
  output logic               wr_ready_o,
  output logic [ByteW-1:0]   start_byte_o,
  output logic [ByteW-1:0]   end_byte_o
);

  logic [ByteW-1:0] start_byte_q, start_byte_d;
  logic [ByteW-1:0] end_byte_q, end_byte_d;

  assign wr_ready_o = 1'b1;

  always_comb begin
    start_byte_d = start_byte_q;
    end_byte_d   = end_byte_q;
    if (wr_valid_i) begin
      unique case (wr_index_i)
        CFG_START_BYTE: start_byte_d = wr_data_i;
        CFG_END_BYTE:   end_byte_d   = wr_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_byte_q <= StartByteRst;
      end_byte_q   <= EndByteRst;
    end else begin
      start_byte_q <= start_byte_d;
      end_byte_q   <= end_byte_d;
    end
  end

  assign start_byte_o = start_byte_q;
  assign end_byte_o   = end_byte_q;

endmodule

/* hdl/sfr_parser.sv */
// frame phase machine: one byte per step, one result per byte
module sfr_parser import sfr_pkg::*; #(
  parameter int unsigned MAX_FRAME_SIZE = MaxFrameSize
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             step_i,
  input  logic [ByteW-1:0] rx_byte_i,
  input  logic [ByteW-1:0] start_byte_i,
  input  logic [ByteW-1:0] end_byte_i,
  output result_t          result_o
);

  localparam logic [SizeW:0] MaxSize  = (SizeW+1)'(MAX_FRAME_SIZE);
  localparam logic [SizeW:0] Overhead = (SizeW+1)'(FrameOverhead);

  phase_e           phase_q, phase_d;
  logic [ByteW-1:0] size_high_q, size_high_d;
  logic [SizeW-1:0] frame_size_q, frame_size_d;
  logic [SizeW-1:0] byte_count_q, byte_count_d;
  logic [ByteW-1:0] type_q, type_d;
  logic [ByteW-1:0] version_q, version_d;

  logic [SizeW-1:0] size_word;
  logic [ByteW:0]   check_sum;
  logic [SizeW-1:0] count_inc;
  logic             payload_last;
  logic             finish;
  result_t          res;

  assign size_word    = {size_high_q, rx_byte_i};
  assign check_sum    = {1'b0, type_q} + (ByteW+1)'(CheckOffset);
  assign count_inc    = byte_count_q + SizeW'(1);
  assign payload_last = ({1'b0, count_inc} + Overhead) >= {1'b0, frame_size_q};

  always_comb begin
    phase_d      = phase_q;
    size_high_d  = size_high_q;
    frame_size_d = frame_size_q;
    byte_count_d = byte_count_q;
    type_d       = type_q;
    version_d    = version_q;
    finish       = 1'b0;
    res.status        = ST_HEADER;
    res.payload_byte  = '0;
    res.payload_index = '0;

    unique case (phase_q)
      PH_HUNT: begin
        if (rx_byte_i == start_byte_i) phase_d = PH_SIZE_HI;
        else res.status = ST_SKIP;
      end
      PH_SIZE_HI: begin
        size_high_d = rx_byte_i;
        phase_d     = PH_SIZE_LO;
      end
      PH_SIZE_LO: begin
        frame_size_d = size_word;
        if ({1'b0, size_word} < Overhead || {1'b0, size_word} > MaxSize) begin
          res.status = ST_BAD_SIZE;
          finish     = 1'b1;
        end else begin
          phase_d = PH_TYPE;
        end
      end
      PH_TYPE: begin
        type_d = rx_byte_i;
        if (rx_byte_i == '0) begin
          res.status = ST_BAD_TYPE;
          finish     = 1'b1;
        end else begin
          phase_d = PH_CHECK;
        end
      end
      PH_CHECK: begin
        // the sum is not wrapped, so a type of 251 or more never matches
        if ({1'b0, rx_byte_i} != check_sum) begin
          res.status = ST_BAD_CHECK;
          finish     = 1'b1;
        end else begin
          phase_d = PH_VERSION;
        end
      end
      PH_VERSION: begin
        version_d = rx_byte_i;
        if (rx_byte_i == '0) begin
          res.status = ST_BAD_VERSION;
          finish     = 1'b1;
        end else if ({1'b0, frame_size_q} == Overhead) begin
          phase_d = PH_END;
        end else begin
          phase_d = PH_PAYLOAD;
        end
      end
      PH_PAYLOAD: begin
        res.status        = ST_PAYLOAD;
        res.payload_byte  = rx_byte_i;
        res.payload_index = byte_count_q[IndexW-1:0];
        byte_count_d      = count_inc;
        if (payload_last) phase_d = PH_END;
      end
      PH_END: begin
        if (rx_byte_i == end_byte_i) begin
          res.status        = ST_DONE;
          res.payload_index = byte_count_q[IndexW-1:0];
        end else begin
          res.status = ST_BAD_END;
        end
        finish = 1'b1;
      end
      default: begin
        res.status = ST_SKIP;
        finish     = 1'b1;
      end
    endcase

    // header values as updated by this byte, cleared on a skipped byte
    if (res.status == ST_SKIP) begin
      res.frame_type    = '0;
      res.frame_version = '0;
    end else begin
      res.frame_type    = type_d;
      res.frame_version = version_d;
    end

    if (finish) begin
      phase_d      = PH_HUNT;
      size_high_d  = '0;
      frame_size_d = '0;
      byte_count_d = '0;
      type_d       = '0;
      version_d    = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PH_HUNT;
      size_high_q  <= '0;
      frame_size_q <= '0;
      byte_count_q <= '0;
      type_q       <= '0;
      version_q    <= '0;
    end else if (step_i) begin
      phase_q      <= phase_d;
      size_high_q  <= size_high_d;
      frame_size_q <= frame_size_d;
      byte_count_q <= byte_count_d;
      type_q       <= type_d;
      version_q    <= version_d;
    end
  end

  assign result_o = res;

endmodule

/* hdl/sfr_out_stage.sv */
// result register with valid flag; refills in the cycle it is emptied
module sfr_out_stage import sfr_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    load_i,
  input  result_t result_i,
  input  logic    out_ready_i,
  output logic    can_load_o,
  output logic    out_valid_o,
  output result_t result_o
);

  logic    valid_q, valid_d;
  result_t result_q;

  assign can_load_o = !valid_q || out_ready_i;

  always_comb begin
    valid_d = valid_q;
    if (load_i) valid_d = 1'b1;
    else if (out_ready_i) valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) valid_q <= 1'b0;
    else valid_q <= valid_d;
  end

  always_ff @(posedge clk_i) begin
    if (load_i) result_q <= result_i;
  end

  assign out_valid_o = valid_q;
  assign result_o    = result_q;

endmodule

/* hdl/serial_frame_receiver_top.sv */
// serial frame receiver top level
//
//   channel  dir  payload                                            accepted when
//   rx_i     in   rx_byte                                            valid & ready
//   res_o    out  status, payload_byte, payload_index, type, version valid & ready
//   cfg_i    in   index (0 start byte, 1 end byte), data             valid & ready
//
// one byte per cycle while rx ready is high; each byte gives one result in the cycle after it is taken
// the phase machine updates in the cycle of acceptance, the result register follows
// rx ready drops only while the result register is full and res ready is low
// reset selects the hunting phase, start byte 2 and end byte 3
module serial_frame_receiver_top import sfr_pkg::*; #(
  parameter int unsigned MAX_FRAME_SIZE = MaxFrameSize
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  sfr_byte_if.sink     rx_i,
  sfr_result_if.source res_o,
  sfr_cfg_if.sink      cfg_i
);

  logic             step;
  logic             can_load;
  logic [ByteW-1:0] start_byte;
  logic [ByteW-1:0] end_byte;
  result_t          parse_res;
  result_t          out_res;

  assign rx_i.ready = can_load;
  assign step       = rx_i.valid && can_load;

  sfr_cfg_regs u_cfg (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .wr_valid_i   (cfg_i.valid),
    .wr_index_i   (cfg_i.index),
    .wr_data_i    (cfg_i.data),
    .wr_ready_o   (cfg_i.ready),
    .start_byte_o (start_byte),
    .end_byte_o   (end_byte)
  );

  sfr_parser #(
    .MAX_FRAME_SIZE (MAX_FRAME_SIZE)
  ) u_parser (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .step_i       (step),
    .rx_byte_i    (rx_i.rx_byte),
    .start_byte_i (start_byte),
    .end_byte_i   (end_byte),
    .result_o     (parse_res)
  );

  sfr_out_stage u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (step),
    .result_i    (parse_res),
    .out_ready_i (res_o.ready),
    .can_load_o  (can_load),
    .out_valid_o (res_o.valid),
    .result_o    (out_res)
  );

  assign res_o.status        = out_res.status;
  assign res_o.payload_byte  = out_res.payload_byte;
  assign res_o.payload_index = out_res.payload_index;
  assign res_o.frame_type    = out_res.frame_type;
  assign res_o.frame_version = out_res.frame_version;

endmodule
